// ===== rtl/okcc_pkg.sv =====
// Package for the online k-means color classifier.
// Holds controller state type, opcodes and the controller/datapath command and status structs.
`timescale 1ns / 1ps
`default_nettype none
package okcc_pkg;
    localparam logic OP_LOAD_SEED = 1'b0;
    localparam logic OP_PIXEL     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_DIVIDE,
        ST_WRITE,
        ST_OUTPUT
    } okcc_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;     // latch input item
        logic load_seed;   // write seed into its cluster
        logic search_init; // clear best and cursor
        logic search_step; // compare one cluster
        logic upd_init;    // compute count and numerators
        logic div_step;    // one quotient bit
        logic write_back;  // store count and centroid
        logic out_load;    // load output register
    } okcc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_pixel;
        logic search_last;
        logic div_last;
    } okcc_stat_t;
endpackage
`default_nettype wire

// ===== rtl/okcc_datapath.sv =====
// Datapath: cluster storage, distance search and bit-serial running-mean divide.
// Depends on okcc_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module okcc_datapath #(
    parameter int MAX_CLUSTERS = 8,
    parameter int COUNT_BITS   = 24,
    parameter int FRAC_BITS    = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire okcc_pkg::okcc_cmd_t cmd,
    output okcc_pkg::okcc_stat_t     stat,
    input  wire logic [3:0]          cluster_count,
    input  wire logic                opcode,
    input  wire logic [2:0]          seed_index,
    input  wire logic [7:0]          red,
    input  wire logic [7:0]          green,
    input  wire logic [7:0]          blue,
    output logic [2:0]               cluster_id,
    output logic [7:0]               out_red,
    output logic [7:0]               out_green,
    output logic [7:0]               out_blue
);
    import okcc_pkg::*;

    localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CW = 8 + FRAC_BITS;
    localparam int DW = 2 * CW + 2;
    localparam int NW = CW + COUNT_BITS + 1;
    localparam int QW = $clog2(NW + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // cluster storage, cleared by reset
    logic [7:0]            seed_reg  [MAX_CLUSTERS][3];
    logic [CW-1:0]         cent_reg  [MAX_CLUSTERS][3];
    logic [COUNT_BITS-1:0] count_reg [MAX_CLUSTERS];

    logic            op_reg;
    logic [2:0]      sidx_reg;
    logic [7:0]      pix_reg [3];
    logic [IW-1:0]   cur_reg, best_reg;
    logic [DW-1:0]   bestd_reg;
    logic            have_reg;
    logic [IW-1:0]   last_idx;
    logic [COUNT_BITS-1:0] n_reg;
    logic [NW-1:0]   num_reg [3];
    logic [NW-1:0]   rem_reg [3];
    logic [NW-1:0]   quo_reg [3];
    logic [QW-1:0]   bit_reg;

    // last searched cluster from the clamped count
    always_comb
    begin
        int act;
        act = int'(cluster_count);
        if (act < 1) act = 1;
        if (act > MAX_CLUSTERS) act = MAX_CLUSTERS;
        last_idx = IW'(act - 1);
    end

    // distance of the current cluster
    logic [DW-1:0] cur_dist;
    always_comb
    begin
        logic [CW-1:0] a, b, d;
        cur_dist = '0;
        for (int c = 0; c < 3; c++)
        begin
            a = cent_reg[cur_reg][c];
            b = {pix_reg[c], {FRAC_BITS{1'b0}}} >> 0;
            d = (a >= b) ? a - b : b - a;
            cur_dist = cur_dist + DW'(d) * DW'(d);
        end
    end

    logic [COUNT_BITS-1:0] n_next;
    always_comb
    begin
        n_next = count_reg[best_reg];
        if (n_next != COUNT_MAX) n_next = n_next + 1'b1;
    end

    assign stat.is_pixel    = op_reg;
    assign stat.search_last = (cur_reg == last_idx);
    assign stat.div_last    = (bit_reg == '0);

    // restoring divider trial values
    logic [NW:0] trial [3];
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            trial[c] = {rem_reg[c], num_reg[c][NW-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_CLUSTERS; k++)
            begin
                count_reg[k] <= '0;
                for (int c = 0; c < 3; c++)
                begin
                    seed_reg[k][c] <= '0;
                    cent_reg[k][c] <= '0;
                end
            end
        end
        else if (cmd.load_seed)
        begin
            if (32'(sidx_reg) < MAX_CLUSTERS)
            begin
                count_reg[sidx_reg[IW-1:0]] <= COUNT_BITS'(1);
                for (int c = 0; c < 3; c++)
                begin
                    seed_reg[sidx_reg[IW-1:0]][c] <= pix_reg[c];
                    cent_reg[sidx_reg[IW-1:0]][c] <= {pix_reg[c], {FRAC_BITS{1'b0}}} >> 0;
                end
            end
        end
        else if (cmd.write_back)
        begin
            count_reg[best_reg] <= n_reg;
            for (int c = 0; c < 3; c++)
                cent_reg[best_reg][c] <= quo_reg[c][CW-1:0];
        end
    end

    // item capture, search and divide
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= opcode;
            sidx_reg   <= seed_index;
            pix_reg[0] <= red;
            pix_reg[1] <= green;
            pix_reg[2] <= blue;
        end
        if (cmd.search_init)
        begin
            cur_reg  <= '0;
            have_reg <= 1'b0;
            best_reg <= '0;
            bestd_reg <= '0;
        end
        else if (cmd.search_step)
        begin
            if (!have_reg || cur_dist < bestd_reg)
            begin
                bestd_reg <= cur_dist;
                best_reg  <= cur_reg;
            end
            have_reg <= 1'b1;
            cur_reg  <= cur_reg + 1'b1;
        end
        if (cmd.upd_init)
        begin
            n_reg   <= n_next;
            bit_reg <= QW'(NW - 1);
            for (int c = 0; c < 3; c++)
            begin
                num_reg[c] <= NW'(cent_reg[best_reg][c]) * NW'(n_next - 1'b1)
                              + NW'({pix_reg[c], {FRAC_BITS{1'b0}}});
                rem_reg[c] <= '0;
                quo_reg[c] <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            bit_reg <= bit_reg - 1'b1;
            for (int c = 0; c < 3; c++)
            begin
                num_reg[c] <= num_reg[c] << 1;
                if (trial[c] >= (NW + 1)'(n_reg))
                begin
                    rem_reg[c] <= NW'(trial[c] - (NW + 1)'(n_reg));
                    quo_reg[c] <= {quo_reg[c][NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[c] <= trial[c][NW-1:0];
                    quo_reg[c] <= {quo_reg[c][NW-2:0], 1'b0};
                end
            end
        end
        if (cmd.out_load)
        begin
            cluster_id <= 3'(best_reg);
            out_red    <= seed_reg[best_reg][0];
            out_green  <= seed_reg[best_reg][1];
            out_blue   <= seed_reg[best_reg][2];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/okcc_ctrl.sv =====
// Controller state machine for the classifier: sequences capture, seed load, search,
// divide and output. Depends on okcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module okcc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    input  wire okcc_pkg::okcc_stat_t stat,
    output okcc_pkg::okcc_cmd_t       cmd
);
    import okcc_pkg::*;

    okcc_state_t state_reg, state_next;
    logic        ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (!stat.is_pixel)
                begin
                    cmd.load_seed = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.search_init = 1'b1;
                    state_next      = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.search_step = 1'b1;
                if (stat.search_last) state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.upd_init = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last) state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                // hold until the output register is free
                if (!ov_reg || !out_stall)
                begin
                    cmd.write_back = 1'b1;
                    cmd.out_load   = 1'b1;
                    ov_next        = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/online_kmeans_color_classifier.sv =====
// Online k-means color classifier, top level.
// Load seed: capture, then write the seed. Pixel: capture, search of the clusters
// (1..8), one cluster a cycle, then a bit-serial running-mean divide, then
// write-back and output load. One item at a time.
// Reset clears all clusters (seed, centroid, count) and sets cluster_count to 8.
`timescale 1ns / 1ps
`default_nettype none
module online_kmeans_color_classifier #(
    parameter int MAX_CLUSTERS = 8,
    parameter int COUNT_BITS   = 24,
    parameter int FRAC_BITS    = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       opcode,
    input  wire logic [2:0] seed_index,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      cluster_id,
    output logic [7:0]      out_red,
    output logic [7:0]      out_green,
    output logic [7:0]      out_blue
);
    import okcc_pkg::*;

    okcc_cmd_t  cmd;
    okcc_stat_t stat;
    logic [3:0] cc_reg;

    // cluster count register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) cc_reg <= 4'd8;
        else if (cfg_valid) cc_reg <= cfg_data;
    end

    okcc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
    );

    okcc_datapath #(
        .MAX_CLUSTERS(MAX_CLUSTERS), .COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .cluster_count(cc_reg),
        .opcode(opcode), .seed_index(seed_index), .red(red), .green(green),
        .blue(blue), .cluster_id(cluster_id), .out_red(out_red),
        .out_green(out_green), .out_blue(out_blue)
    );
endmodule
`default_nettype wire

// ===== rtl/okcc_checker.sv =====
// Port-level checker for the classifier, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
`default_nettype none
module okcc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [2:0] cluster_id
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cluster_id))
        else $error("stalled result changed");
    // an accepted item stalls the input in the following cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while busy");
    // a result never appears right after an acceptance
    a_no_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result too early");
endmodule

bind online_kmeans_color_classifier okcc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cluster_id(cluster_id)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the online k-means color classifier.
// Drives seed and pixel transfers, predicts each result in place, checks outputs.
// Depends on rtl/okcc_pkg.sv and rtl/online_kmeans_color_classifier.sv.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import okcc_pkg::*;

    localparam int NCL       = 8;
    localparam int CNT_MAX   = (1 << 24) - 1;
    localparam int IDLE_WAIT = 80;
    localparam int LIMIT     = 4000000;

    typedef struct packed {
        logic [2:0] id;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } color_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic opcode = OP_LOAD_SEED;
    logic [2:0] seed_index = '0;
    logic [7:0] red = '0, green = '0, blue = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] cluster_id;
    logic [7:0] out_red, out_green, out_blue;

    // predictor state
    logic [3:0]  active_cfg;
    logic [7:0]  seed_rgb [NCL][3];
    logic [15:0] cent [NCL][3];
    int unsigned members [NCL];
    color_result_t expected_colors[$];

    int mismatches = 0;
    int cycles = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;

    online_kmeans_color_classifier dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .seed_index(seed_index),
        .red(red), .green(green), .blue(blue),
        .out_valid(out_valid), .out_stall(out_stall),
        .cluster_id(cluster_id), .out_red(out_red),
        .out_green(out_green), .out_blue(out_blue)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stall, with long hold-off counted here
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        color_result_t got, exp_c;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{cluster_id, out_red, out_green, out_blue};
            if (expected_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                exp_c = expected_colors.pop_front();
                if (got !== exp_c)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected id %0d rgb %h %h %h, got id %0d rgb %h %h %h",
                            exp_c.id, exp_c.r, exp_c.g, exp_c.b,
                            got.id, got.r, got.g, got.b);
                end
            end
        end
    end

    // nearest-centroid search and running-mean update
    function automatic void classify_pixel(logic [7:0] p[3]);
        int unsigned act, best, n;
        longint unsigned d, best_d, df, num;
        color_result_t res;
        act = (active_cfg == 0) ? 1 : (active_cfg > NCL ? NCL : active_cfg);
        best = 0;
        best_d = 0;
        for (int k = 0; k < act; k++)
        begin
            d = 0;
            for (int c = 0; c < 3; c++)
            begin
                df = (cent[k][c] >= {p[c], 8'h00}) ? cent[k][c] - {p[c], 8'h00}
                                                  : {p[c], 8'h00} - cent[k][c];
                d += df * df;
            end
            if (k == 0 || d < best_d)
            begin
                best_d = d;
                best = k;
            end
        end
        res = '{3'(best), seed_rgb[best][0], seed_rgb[best][1], seed_rgb[best][2]};
        expected_colors = {expected_colors, res};
        n = members[best];
        if (n < CNT_MAX)
            n++;
        members[best] = n;
        for (int c = 0; c < 3; c++)
        begin
            num = longint'(cent[best][c]) * (n - 1) + {p[c], 8'h00};
            cent[best][c] = 16'(num / n);
        end
    endfunction

    // one input transfer, predicted when accepted; valid is dropped by the next driver
    task automatic send_item(logic op, logic [2:0] idx, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b);
        logic [7:0] p[3];
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        seed_index <= idx;
        red <= r;
        green <= g;
        blue <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p[0] = r; p[1] = g; p[2] = b;
        if (op == OP_LOAD_SEED)
        begin
            for (int c = 0; c < 3; c++)
            begin
                seed_rgb[idx][c] = p[c];
                cent[idx][c] = {p[c], 8'h00};
            end
            members[idx] = 1;
        end
        else
            classify_pixel(p);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_colors.size() != 0)
            @(negedge clk);
        repeat (IDLE_WAIT) @(negedge clk);
    endtask

    task automatic write_count(logic [3:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        active_cfg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic rand_pixel();
        send_item(OP_PIXEL, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic rand_seed();
        send_item(OP_LOAD_SEED, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // unseeded clusters, extremes, ties, count zero and above range
    task automatic test_directed();
        send_item(OP_PIXEL, 3'd0, 8'd0, 8'd0, 8'd0);
        send_item(OP_PIXEL, 3'd7, 8'd255, 8'd255, 8'd255);
        send_item(OP_LOAD_SEED, 3'd0, 8'd255, 8'd0, 8'd0);
        send_item(OP_LOAD_SEED, 3'd1, 8'd0, 8'd255, 8'd0);
        send_item(OP_LOAD_SEED, 3'd2, 8'd0, 8'd0, 8'd255);
        send_item(OP_LOAD_SEED, 3'd7, 8'd255, 8'd255, 8'd255);
        send_item(OP_LOAD_SEED, 3'd3, 8'd255, 8'd0, 8'd0);
        send_item(OP_PIXEL, 3'd0, 8'd255, 8'd0, 8'd0);
        send_item(OP_PIXEL, 3'd0, 8'd128, 8'd128, 8'd0);
        send_item(OP_PIXEL, 3'd5, 8'd255, 8'd255, 8'd255);
        send_item(OP_PIXEL, 3'd0, 8'd0, 8'd0, 8'd0);
        send_item(OP_PIXEL, 3'd0, 8'd1, 8'd254, 8'd127);
        write_count(4'd0);
        send_item(OP_PIXEL, 3'd0, 8'd0, 8'd255, 8'd0);
        write_count(4'd1);
        send_item(OP_PIXEL, 3'd0, 8'd10, 8'd20, 8'd30);
        write_count(4'd15);
        send_item(OP_PIXEL, 3'd0, 8'd255, 8'd255, 8'd250);
        write_count(4'd9);
        send_item(OP_PIXEL, 3'd0, 8'd3, 8'd3, 8'd3);
        write_count(4'd8);
    endtask

    // random mix, mostly pixels, sometimes reseeding
    task automatic test_random(int items);
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(99) < 12)
                rand_seed();
            else
                rand_pixel();
        end
    endtask

    // receiver holds off while sender keeps offering
    task automatic test_backpressure();
        drain();
        hold_off = 400;
        repeat (20) rand_pixel();
        drain();
    endtask

    initial
    begin
        active_cfg = 4'd8;
        for (int k = 0; k < NCL; k++)
        begin
            members[k] = 0;
            for (int c = 0; c < 3; c++)
            begin
                seed_rgb[k][c] = '0;
                cent[k][c] = '0;
            end
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        send_gap_pct = 31; recv_stall_pct = 79;
        test_random(400);
        write_count(4'd3);
        send_gap_pct = 79; recv_stall_pct = 31;
        test_random(400);
        write_count(4'd5);
        send_gap_pct = 0; recv_stall_pct = 0;
        test_backpressure();
        test_random(250);
        write_count(4'd8);
        test_random(250);
        drain();
        if (mismatches == 0 && expected_colors.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/okcc_pkg.sv
rtl/okcc_datapath.sv
rtl/okcc_ctrl.sv
rtl/online_kmeans_color_classifier.sv
rtl/okcc_checker.sv
sim/tb_top.sv
